// File: rtl/grc_pkg.sv
// Shared constants, codes and control types for the grid ray caster.
package grc_pkg;

  // Geometry and limits.
  localparam int GRID_SIDE   = 16;
  localparam int COLUMNS     = 64;
  localparam int SCREEN_ROWS = 64;
  localparam int MAX_STEPS   = 32;

  // Derived widths.
  localparam int AW        = $clog2(GRID_SIDE);
  localparam int MW        = AW + 2;
  localparam int SW        = $clog2(MAX_STEPS + 1);
  localparam int DIV_W     = 31;
  localparam int DVS_W     = 18;
  localparam int SD_W      = 40;
  localparam int CAM_SHIFT = 15 - $clog2(COLUMNS);
  localparam int ROWS_HALF = SCREEN_ROWS / 2;

  // Fixed-point constants.
  localparam logic [DIV_W-1:0] ONE_Q30   = 31'h4000_0000;
  localparam logic [DIV_W-1:0] HGT_NUM   = DIV_W'(SCREEN_ROWS * 256);
  localparam logic [14:0]      HGT_ZERO  = 15'(SCREEN_ROWS * 4);
  localparam logic [31:0]      DELTA_SAT = 32'hFFFF_FFFF;
  localparam logic [15:0]      DIST_SAT  = 16'hFFFF;

  // Action codes of an input word.
  localparam logic ACT_WRITE = 1'b0;
  localparam logic ACT_CAST  = 1'b1;

  typedef enum logic [3:0] {
    ST_IDLE, ST_RAY1, ST_RAY2, ST_RAY3, ST_DDX, ST_DDY, ST_SIDE1, ST_SIDE2,
    ST_SIDE3, ST_WALK, ST_CHECK, ST_DDIST, ST_HGO, ST_DHGT, ST_FIN, ST_MISS
  } state_t;

  typedef enum logic [2:0] {MUL_NONE, MUL_PX, MUL_PY, MUL_FX, MUL_FY} mul_op_t;
  typedef enum logic [2:0] {ACC_NONE, ACC_RX, ACC_RY, ACC_SX, ACC_SY} acc_op_t;
  typedef enum logic [1:0] {DIV_DX, DIV_DY, DIV_DIST, DIV_HGT} div_op_t;

  typedef struct packed {
    logic    cap;
    logic    wr;
    mul_op_t mul;
    acc_op_t acc;
    logic    div_go;
    div_op_t div_op;
    logic    step;
    logic    fin;
    logic    found;
  } ctrl_cmd_t;

  typedef struct packed {
    logic div_done;
    logic in_grid;
    logic wall;
    logic steps_max;
    logic out_free;
  } ctrl_sts_t;

endpackage

// File: rtl/grid_raycast_column.sv
// Top level of the column ray caster: controller plus datapath.
//
//   channel | direction | handshake             | word
//   in_     | input     | in_valid / in_ready   | cell write or column cast
//   out_    | output    | out_valid / out_ready | one result per cast
//
// A cell write gives no result. A cast walks N grid steps (N up to 32); a hit
// needs four passes of the shared one-bit-per-cycle divider, a miss only two.
// Reset is synchronous and active low; it clears the grid valid bits at once.
// The result sits in an output register, so a new word is taken while it waits;
// a finished cast stalls only if the previous result has not been taken.
module grid_raycast_column (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic               in_action,
  input  logic [3:0]         in_cell_x,
  input  logic [3:0]         in_cell_y,
  input  logic               in_cell_wall,
  input  logic [15:0]        in_view_x,
  input  logic [15:0]        in_view_y,
  input  logic signed [15:0] in_heading_x,
  input  logic signed [15:0] in_heading_y,
  input  logic signed [15:0] in_plane_x_in,
  input  logic signed [15:0] in_plane_y_in,
  input  logic [5:0]         in_column,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [5:0]         out_column_out,
  output logic [5:0]         out_slice_top,
  output logic [5:0]         out_slice_bottom,
  output logic [15:0]        out_wall_distance,
  output logic               out_wall_side,
  output logic               out_wall_found
);
  import grc_pkg::*;

  ctrl_cmd_t cmd;
  ctrl_sts_t sts;

  // Sequencer.
  grc_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_action (in_action),
    .in_ready  (in_ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  // Arithmetic, grid and result register.
  grc_dpath u_dpath (
    .clk               (clk),
    .rst_n             (rst_n),
    .cmd               (cmd),
    .sts               (sts),
    .in_cell_x         (in_cell_x),
    .in_cell_y         (in_cell_y),
    .in_cell_wall      (in_cell_wall),
    .in_view_x         (in_view_x),
    .in_view_y         (in_view_y),
    .in_heading_x      (in_heading_x),
    .in_heading_y      (in_heading_y),
    .in_plane_x_in     (in_plane_x_in),
    .in_plane_y_in     (in_plane_y_in),
    .in_column         (in_column),
    .out_ready         (out_ready),
    .out_valid         (out_valid),
    .out_column_out    (out_column_out),
    .out_slice_top     (out_slice_top),
    .out_slice_bottom  (out_slice_bottom),
    .out_wall_distance (out_wall_distance),
    .out_wall_side     (out_wall_side),
    .out_wall_found    (out_wall_found)
  );

endmodule

// File: rtl/grc_ctrl.sv
// Controller state machine that accepts cell writes and sequences one cast through the datapath.
module grc_ctrl (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  input  logic                 in_action,
  output logic                 in_ready,
  input  grc_pkg::ctrl_sts_t   sts,
  output grc_pkg::ctrl_cmd_t   cmd
);
  import grc_pkg::*;

  state_t state_r, state_nxt;

  // State register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Next state and commands.
  always_comb begin
    state_nxt  = state_r;
    in_ready   = 1'b0;
    cmd        = '0;
    cmd.mul    = MUL_NONE;
    cmd.acc    = ACC_NONE;
    cmd.div_op = DIV_DX;
    case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          if (in_action == ACT_CAST) begin
            cmd.cap   = 1'b1;
            state_nxt = ST_RAY1;
          end else begin
            cmd.wr = 1'b1;
          end
        end
      end
      ST_RAY1: begin
        cmd.mul   = MUL_PX;
        state_nxt = ST_RAY2;
      end
      ST_RAY2: begin
        cmd.mul   = MUL_PY;
        cmd.acc   = ACC_RX;
        state_nxt = ST_RAY3;
      end
      ST_RAY3: begin
        cmd.acc    = ACC_RY;
        cmd.div_go = 1'b1;
        cmd.div_op = DIV_DX;
        state_nxt  = ST_DDX;
      end
      ST_DDX: begin
        if (sts.div_done) begin
          cmd.div_go = 1'b1;
          cmd.div_op = DIV_DY;
          state_nxt  = ST_DDY;
        end
      end
      ST_DDY: begin
        if (sts.div_done) begin
          state_nxt = ST_SIDE1;
        end
      end
      ST_SIDE1: begin
        cmd.mul   = MUL_FX;
        state_nxt = ST_SIDE2;
      end
      ST_SIDE2: begin
        cmd.mul   = MUL_FY;
        cmd.acc   = ACC_SX;
        state_nxt = ST_SIDE3;
      end
      ST_SIDE3: begin
        cmd.acc   = ACC_SY;
        state_nxt = sts.in_grid ? ST_WALK : ST_MISS;
      end
      ST_WALK: begin
        cmd.step  = 1'b1;
        state_nxt = ST_CHECK;
      end
      ST_CHECK: begin
        if (!sts.in_grid) begin
          state_nxt = ST_MISS;
        end else if (sts.wall) begin
          cmd.div_go = 1'b1;
          cmd.div_op = DIV_DIST;
          state_nxt  = ST_DDIST;
        end else if (sts.steps_max) begin
          state_nxt = ST_MISS;
        end else begin
          cmd.step = 1'b1;
        end
      end
      ST_DDIST: begin
        if (sts.div_done) begin
          state_nxt = ST_HGO;
        end
      end
      ST_HGO: begin
        cmd.div_go = 1'b1;
        cmd.div_op = DIV_HGT;
        state_nxt  = ST_DHGT;
      end
      ST_DHGT: begin
        if (sts.div_done) begin
          state_nxt = ST_FIN;
        end
      end
      ST_FIN: begin
        if (sts.out_free) begin
          cmd.fin   = 1'b1;
          cmd.found = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      ST_MISS: begin
        if (sts.out_free) begin
          cmd.fin   = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

endmodule

// File: rtl/grc_dpath.sv
// Datapath: wall grid memory, shared multiplier, shared divider, DDA walk and result register.
module grc_dpath (
  input  logic                 clk,
  input  logic                 rst_n,
  input  grc_pkg::ctrl_cmd_t   cmd,
  output grc_pkg::ctrl_sts_t   sts,
  input  logic [3:0]           in_cell_x,
  input  logic [3:0]           in_cell_y,
  input  logic                 in_cell_wall,
  input  logic [15:0]          in_view_x,
  input  logic [15:0]          in_view_y,
  input  logic signed [15:0]   in_heading_x,
  input  logic signed [15:0]   in_heading_y,
  input  logic signed [15:0]   in_plane_x_in,
  input  logic signed [15:0]   in_plane_y_in,
  input  logic [5:0]           in_column,
  input  logic                 out_ready,
  output logic                 out_valid,
  output logic [5:0]           out_column_out,
  output logic [5:0]           out_slice_top,
  output logic [5:0]           out_slice_bottom,
  output logic [15:0]          out_wall_distance,
  output logic                 out_wall_side,
  output logic                 out_wall_found
);
  import grc_pkg::*;

  localparam int NCELL = GRID_SIDE * GRID_SIDE;

  // Captured cast operands.
  logic [15:0]        vx_r, vy_r;
  logic signed [15:0] hx_r, hy_r, px_r, py_r;
  logic [5:0]         col_r;
  logic signed [16:0] cam_r;

  // Ray, deltas, side distances and walk position.
  logic signed [51:0]   prod_r;
  logic signed [17:0]   rx_r, ry_r;
  logic [31:0]          dx_r, dy_r;
  logic [SD_W-1:0]      sx_r, sy_r;
  logic signed [MW-1:0] mx_r, my_r;
  logic                 side_r;
  logic [SW-1:0]        cnt_r;
  logic [15:0]          dist_r;
  logic [14:0]          hgt_r;

  // Divider state.
  logic [DVS_W-1:0] div_rem_r, div_dvs_r;
  logic [DIV_W-1:0] div_quo_r;
  logic [4:0]       div_cnt_r;
  logic             div_busy_r, div_done_r;
  div_op_t          div_op_r;

  // Grid memory and its valid bits.
  logic             mem [NCELL];
  logic [NCELL-1:0] vld_r;
  logic             rd_mem_r, rd_vld_r;

  // Result register.
  logic       out_valid_r;
  logic [5:0] out_col_r, out_top_r, out_bot_r;
  logic [15:0] out_dist_r;
  logic       out_side_r, out_found_r;

  // Shared multiplier operands.
  logic signed [33:0] mul_a;
  logic signed [17:0] mul_b;
  logic signed [51:0] mul_p;
  logic [11:0]        fx, fy;
  logic [12:0]        fxs, fys;

  assign fx  = vx_r[11:0];
  assign fy  = vy_r[11:0];
  assign fxs = rx_r[17] ? {1'b0, fx} : 13'd4096 - {1'b0, fx};
  assign fys = ry_r[17] ? {1'b0, fy} : 13'd4096 - {1'b0, fy};

  always_comb begin
    case (cmd.mul)
      MUL_PX: begin
        mul_a = 34'(px_r);
        mul_b = 18'(cam_r);
      end
      MUL_PY: begin
        mul_a = 34'(py_r);
        mul_b = 18'(cam_r);
      end
      MUL_FX: begin
        mul_a = $signed({2'b00, dx_r});
        mul_b = $signed({5'b0, fxs});
      end
      MUL_FY: begin
        mul_a = $signed({2'b00, dy_r});
        mul_b = $signed({5'b0, fys});
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign mul_p = mul_a * mul_b;

  // Ray component: heading plus plane term truncated toward zero.
  logic signed [51:0] prod_adj;
  logic signed [17:0] ray_t;
  logic signed [17:0] hsel;

  assign prod_adj = prod_r + (prod_r[51] ? 52'sd16383 : 52'sd0);
  assign ray_t    = prod_adj[31:14];
  assign hsel     = (cmd.acc == ACC_RX) ? 18'(hx_r) : 18'(hy_r);

  // Distance numerator on the axis that was hit.
  logic signed [MW-1:0] m_hit;
  logic signed [17:0]   r_hit;
  logic [15:0]          v_hit;
  logic signed [MW:0]   c_adj;
  logic signed [MW+12:0] num;
  logic [MW+12:0]       num_abs;
  logic [17:0]          r_abs, rx_abs, ry_abs;

  assign m_hit   = side_r ? my_r : mx_r;
  assign r_hit   = side_r ? ry_r : rx_r;
  assign v_hit   = side_r ? vy_r : vx_r;
  assign c_adj   = (MW+1)'(m_hit) + (MW+1)'(r_hit[17]);
  assign num     = $signed({c_adj, 12'b0}) - $signed((MW+13)'(v_hit));
  assign num_abs = num[MW+12] ? (MW+13)'(-num) : $unsigned(num);
  assign rx_abs  = rx_r[17] ? 18'(-rx_r) : $unsigned(rx_r);
  assign ry_abs  = ry_r[17] ? 18'(-ry_r) : $unsigned(ry_r);
  assign r_abs   = side_r ? ry_abs : rx_abs;

  // Divider operand selection at start.
  logic [DIV_W-1:0] dd_sel;
  logic [DVS_W-1:0] dv_sel;

  always_comb begin
    case (cmd.div_op)
      DIV_DX: begin
        dd_sel = ONE_Q30;
        dv_sel = rx_abs;
      end
      DIV_DY: begin
        dd_sel = ONE_Q30;
        dv_sel = ry_abs;
      end
      DIV_DIST: begin
        dd_sel = DIV_W'({num_abs[16:0], 10'b0});
        dv_sel = r_abs;
      end
      default: begin
        dd_sel = HGT_NUM;
        dv_sel = {2'b00, dist_r};
      end
    endcase
  end

  // One restoring division step.
  logic [DVS_W:0] div_trial;
  logic           div_ge;

  assign div_trial = {div_rem_r, div_quo_r[DIV_W-1]};
  assign div_ge    = div_trial >= {1'b0, div_dvs_r};

  // Divider control.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      div_busy_r <= 1'b0;
      div_done_r <= 1'b0;
    end else begin
      div_done_r <= div_busy_r && (div_cnt_r == 5'd1);
      if (cmd.div_go) begin
        div_busy_r <= 1'b1;
      end else if (div_busy_r && (div_cnt_r == 5'd1)) begin
        div_busy_r <= 1'b0;
      end
    end
  end

  // Divider datapath, one quotient bit per cycle.
  always_ff @(posedge clk) begin
    if (cmd.div_go) begin
      div_rem_r <= '0;
      div_quo_r <= dd_sel;
      div_dvs_r <= dv_sel;
      div_cnt_r <= 5'(DIV_W);
      div_op_r  <= cmd.div_op;
    end else if (div_busy_r) begin
      div_rem_r <= div_ge ? DVS_W'(div_trial - {1'b0, div_dvs_r}) : div_trial[DVS_W-1:0];
      div_quo_r <= {div_quo_r[DIV_W-2:0], div_ge};
      div_cnt_r <= div_cnt_r - 5'd1;
    end
  end

  // Walk step: advance along the axis with the smaller side distance; a tie steps along y.
  logic                 step_x;
  logic signed [MW-1:0] mx_step, my_step, mx_rd, my_rd;
  logic [2*AW-1:0]      rd_addr, wr_addr;

  assign step_x  = sx_r < sy_r;
  assign mx_step = rx_r[17] ? mx_r - MW'(1) : mx_r + MW'(1);
  assign my_step = ry_r[17] ? my_r - MW'(1) : my_r + MW'(1);
  assign mx_rd   = step_x ? mx_step : mx_r;
  assign my_rd   = step_x ? my_r : my_step;
  assign rd_addr = {my_rd[AW-1:0], mx_rd[AW-1:0]};
  assign wr_addr = {in_cell_y[AW-1:0], in_cell_x[AW-1:0]};

  // Operand capture, ray, deltas and walk registers.
  always_ff @(posedge clk) begin
    if (cmd.cap) begin
      vx_r  <= in_view_x;
      vy_r  <= in_view_y;
      hx_r  <= in_heading_x;
      hy_r  <= in_heading_y;
      px_r  <= in_plane_x_in;
      py_r  <= in_plane_y_in;
      col_r <= in_column;
      cam_r <= $signed(17'({1'b0, in_column} << CAM_SHIFT)) - 17'sd16384;
      mx_r  <= MW'(in_view_x[15:12]);
      my_r  <= MW'(in_view_y[15:12]);
      cnt_r <= '0;
      side_r <= 1'b0;
    end
    if (cmd.mul != MUL_NONE) begin
      prod_r <= mul_p;
    end
    case (cmd.acc)
      ACC_RX:  rx_r <= hsel + ray_t;
      ACC_RY:  ry_r <= hsel + ray_t;
      ACC_SX:  sx_r <= SD_W'(prod_r[44:12]);
      ACC_SY:  sy_r <= SD_W'(prod_r[44:12]);
      default: ;
    endcase
    if (div_done_r) begin
      case (div_op_r)
        DIV_DX: dx_r <= (rx_r == 18'sd0) ? DELTA_SAT : {1'b0, div_quo_r};
        DIV_DY: dy_r <= (ry_r == 18'sd0) ? DELTA_SAT : {1'b0, div_quo_r};
        DIV_DIST: begin
          if (r_hit == 18'sd0) begin
            dist_r <= DIST_SAT;
          end else if (num == '0 || (num[MW+12] != r_hit[17])) begin
            dist_r <= '0;
          end else if (div_quo_r > DIV_W'(DIST_SAT)) begin
            dist_r <= DIST_SAT;
          end else begin
            dist_r <= div_quo_r[15:0];
          end
        end
        default: hgt_r <= div_quo_r[14:0];
      endcase
    end
    if (cmd.step) begin
      cnt_r <= cnt_r + SW'(1);
      if (step_x) begin
        sx_r   <= sx_r + SD_W'(dx_r);
        mx_r   <= mx_step;
        side_r <= 1'b0;
      end else begin
        sy_r   <= sy_r + SD_W'(dy_r);
        my_r   <= my_step;
        side_r <= 1'b1;
      end
    end
  end

  // Grid memory: one write port, one registered read port.
  always_ff @(posedge clk) begin
    if (cmd.wr) begin
      mem[wr_addr] <= in_cell_wall;
    end
    if (cmd.step) begin
      rd_mem_r <= mem[rd_addr];
      rd_vld_r <= vld_r[rd_addr];
    end
  end

  // Valid bits: a cell never written reads as open floor.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (cmd.wr) begin
      vld_r[wr_addr] <= 1'b1;
    end
  end

  // Slice rows from the wall height.
  logic [14:0] hgt_eff;
  logic [13:0] half;
  logic        half_big;
  logic [5:0]  top_v, bot_v;

  assign hgt_eff  = (dist_r == 16'd0) ? HGT_ZERO : hgt_r;
  assign half     = hgt_eff[14:1];
  assign half_big = half >= 14'(ROWS_HALF);
  assign top_v    = half_big ? 6'd0 : 6'(ROWS_HALF - int'(half));
  assign bot_v    = half_big ? 6'(SCREEN_ROWS - 1) : 6'(ROWS_HALF + int'(half));

  // Result register and its valid flag.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.fin) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.fin) begin
      out_col_r   <= col_r;
      out_found_r <= cmd.found;
      if (cmd.found) begin
        out_top_r  <= top_v;
        out_bot_r  <= bot_v;
        out_dist_r <= dist_r;
        out_side_r <= side_r;
      end else begin
        out_top_r  <= '0;
        out_bot_r  <= '0;
        out_dist_r <= DIST_SAT;
        out_side_r <= 1'b0;
      end
    end
  end

  assign out_valid         = out_valid_r;
  assign out_column_out    = out_col_r;
  assign out_slice_top     = out_top_r;
  assign out_slice_bottom  = out_bot_r;
  assign out_wall_distance = out_dist_r;
  assign out_wall_side     = out_side_r;
  assign out_wall_found    = out_found_r;

  // Status back to the controller.
  assign sts.div_done  = div_done_r;
  assign sts.in_grid   = !mx_r[MW-1] && !my_r[MW-1] &&
                         ($unsigned(mx_r) < MW'(GRID_SIDE)) &&
                         ($unsigned(my_r) < MW'(GRID_SIDE));
  assign sts.wall      = rd_mem_r && rd_vld_r;
  assign sts.steps_max = cnt_r == SW'(MAX_STEPS);
  assign sts.out_free  = !out_valid_r || out_ready;

endmodule

// File: rtl/grc_checker.sv
// Port-level checker for the ray caster, bound to the top level.
module grc_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_ready,
  input logic        in_action,
  input logic        out_valid,
  input logic        out_ready,
  input logic [5:0]  out_slice_top,
  input logic [5:0]  out_slice_bottom,
  input logic [15:0] out_wall_distance,
  input logic        out_wall_side,
  input logic        out_wall_found
);
  import grc_pkg::*;

  // A stalled result word stays valid.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result word dropped while stalled");

  // A stalled result word keeps its distance.
  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> $stable(out_wall_distance))
    else $error("result word changed while stalled");

  // A miss carries the fixed miss fields.
  a_miss_shape: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_wall_found |-> out_wall_distance == 16'hFFFF &&
      out_slice_top == 6'd0 && out_slice_bottom == 6'd0 && !out_wall_side)
    else $error("miss word has wrong fields");

  // A zero distance fills the whole column.
  a_zero_dist: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_wall_found && out_wall_distance == 16'd0 |->
      out_slice_top == 6'd0 && out_slice_bottom == 6'(SCREEN_ROWS - 1))
    else $error("zero distance slice not full height");

  // A cell write never creates a result word.
  a_write_silent: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && in_action == ACT_WRITE && !out_valid |=> !out_valid)
    else $error("cell write produced a result");

endmodule

bind grid_raycast_column grc_checker u_grc_checker (.*);

// File: verif/grc_checker.sv
// Checker for the grid ray caster: mirrors the wall grid, predicts results and compares them.
`timescale 1ns / 1ps

module grc_scoreboard
  import grc_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  logic               in_ready,
  input  logic               in_action,
  input  logic [3:0]         in_cell_x,
  input  logic [3:0]         in_cell_y,
  input  logic               in_cell_wall,
  input  logic [15:0]        in_view_x,
  input  logic [15:0]        in_view_y,
  input  logic signed [15:0] in_heading_x,
  input  logic signed [15:0] in_heading_y,
  input  logic signed [15:0] in_plane_x_in,
  input  logic signed [15:0] in_plane_y_in,
  input  logic [5:0]         in_column,
  input  logic               out_valid,
  input  logic               out_ready,
  input  logic [5:0]         out_column_out,
  input  logic [5:0]         out_slice_top,
  input  logic [5:0]         out_slice_bottom,
  input  logic [15:0]        out_wall_distance,
  input  logic               out_wall_side,
  input  logic               out_wall_found,
  output int                 fail_count,
  output int                 pending
);

  typedef struct packed {
    logic [5:0]  column;
    logic [5:0]  top;
    logic [5:0]  bottom;
    logic [15:0] distance;
    logic        side;
    logic        found;
  } column_hit_t;

  // Local copy of the wall map, indexed [y][x].
  bit          wall_map [GRID_SIDE][GRID_SIDE];
  column_hit_t hits_due [$];

  // Walks one column ray through the mirrored map and returns the wall slice.
  function automatic column_hit_t cast_column(input logic [15:0] vx, input logic [15:0] vy,
                                             input logic signed [15:0] hx,
                                             input logic signed [15:0] hy,
                                             input logic signed [15:0] px,
                                             input logic signed [15:0] py,
                                             input logic [5:0] col);
    longint          cam, rx, ry, mx, my, stx, sty, num, r, q, h, top, bot;
    longint unsigned dx, dy, sx, sy, fx, fy, ax, ay;
    bit              side, found, in_grid;
    int              n;
    column_hit_t     res;
    cam = (longint'(col) * 2 * 16384) / COLUMNS - 16384;
    rx  = longint'(hx) + (longint'(px) * cam) / 16384;
    ry  = longint'(hy) + (longint'(py) * cam) / 16384;
    mx  = longint'(vx[15:12]);
    my  = longint'(vy[15:12]);
    fx  = longint'(vx[11:0]);
    fy  = longint'(vy[11:0]);
    ax  = (rx < 0) ? -rx : rx;
    ay  = (ry < 0) ? -ry : ry;
    dx  = (rx == 0) ? 64'(DELTA_SAT) : (64'd1 << 30) / ax;
    dy  = (ry == 0) ? 64'(DELTA_SAT) : (64'd1 << 30) / ay;
    if (rx < 0) begin
      stx = -1; sx = (fx * dx) >> 12;
    end else begin
      stx = 1;  sx = ((4096 - fx) * dx) >> 12;
    end
    if (ry < 0) begin
      sty = -1; sy = (fy * dy) >> 12;
    end else begin
      sty = 1;  sy = ((4096 - fy) * dy) >> 12;
    end
    side    = 0;
    found   = 0;
    in_grid = (mx >= 0 && my >= 0 && mx < GRID_SIDE && my < GRID_SIDE);
    // The starting cell is skipped; every stepped-into cell is tested.
    for (n = 0; in_grid && n < MAX_STEPS; n++) begin
      if (sx < sy) begin
        sx += dx; mx += stx; side = 0;
      end else begin
        sy += dy; my += sty; side = 1;
      end
      in_grid = (mx >= 0 && my >= 0 && mx < GRID_SIDE && my < GRID_SIDE);
      if (in_grid && wall_map[my][mx]) begin
        found = 1;
        break;
      end
    end
    res = '0;
    res.column = col;
    if (!found) begin
      res.distance = DIST_SAT;
      return res;
    end
    if (side == 0) begin
      num = (mx + ((stx < 0) ? 1 : 0)) * 4096 - longint'(vx);
      r   = rx;
    end else begin
      num = (my + ((sty < 0) ? 1 : 0)) * 4096 - longint'(vy);
      r   = ry;
    end
    // A zero component on the hit axis saturates the distance.
    if (r == 0) begin
      q = 65535;
    end else begin
      q = (num * 1024) / r;
      if (q < 0) q = 0;
      if (q > 65535) q = 65535;
    end
    h   = (q == 0) ? SCREEN_ROWS * 4 : (SCREEN_ROWS * 256) / q;
    top = ROWS_HALF - h / 2;
    if (top < 0) top = 0;
    bot = h / 2 + ROWS_HALF;
    if (bot >= SCREEN_ROWS) bot = SCREEN_ROWS - 1;
    res.top      = top[5:0];
    res.bottom   = bot[5:0];
    res.distance = q[15:0];
    res.side     = side;
    res.found    = 1;
    return res;
  endfunction

  task automatic report_mismatch(input string what, input longint want, input longint got);
    $display("%0t: mismatch on %s: expected %0d, got %0d", $realtime, what, want, got);
    fail_count++;
  endtask

  // Track accepted words and compare each result word against the oldest prediction.
  always @(posedge clk) begin
    column_hit_t want;
    if (!rst_n) begin
      foreach (wall_map[y, x]) wall_map[y][x] = 0;
      hits_due.delete();
    end else begin
      if (in_valid && in_ready) begin
        if (in_action == ACT_WRITE)
          wall_map[in_cell_y][in_cell_x] = in_cell_wall;
        else
          hits_due.push_back(cast_column(in_view_x, in_view_y, in_heading_x, in_heading_y,
                                         in_plane_x_in, in_plane_y_in, in_column));
      end
      if (out_valid && out_ready) begin
        if (hits_due.size() == 0) begin
          report_mismatch("unexpected result word, column", -1, out_column_out);
        end else begin
          want = hits_due.pop_front();
          if (out_column_out != want.column)
            report_mismatch("column_out", want.column, out_column_out);
          if (out_slice_top != want.top)
            report_mismatch("slice_top", want.top, out_slice_top);
          if (out_slice_bottom != want.bottom)
            report_mismatch("slice_bottom", want.bottom, out_slice_bottom);
          if (out_wall_distance != want.distance)
            report_mismatch("wall_distance", want.distance, out_wall_distance);
          if (out_wall_side != want.side)
            report_mismatch("wall_side", want.side, out_wall_side);
          if (out_wall_found != want.found)
            report_mismatch("wall_found", want.found, out_wall_found);
        end
      end
    end
    pending = hits_due.size();
  end

  initial begin
    fail_count = 0;
    pending    = 0;
  end

endmodule

// File: verif/tb_grid_raycast_column.sv
// Stimulus and verdict for the grid ray caster regression.
`timescale 1ns / 1ps

module tb_grid_raycast_column;
  import grc_pkg::*;

  logic               clk;
  logic               rst_n;
  logic               in_valid;
  logic               in_ready;
  logic               in_action;
  logic [3:0]         in_cell_x;
  logic [3:0]         in_cell_y;
  logic               in_cell_wall;
  logic [15:0]        in_view_x;
  logic [15:0]        in_view_y;
  logic signed [15:0] in_heading_x;
  logic signed [15:0] in_heading_y;
  logic signed [15:0] in_plane_x_in;
  logic signed [15:0] in_plane_y_in;
  logic [5:0]         in_column;
  logic               out_valid;
  logic               out_ready;
  logic [5:0]         out_column_out;
  logic [5:0]         out_slice_top;
  logic [5:0]         out_slice_bottom;
  logic [15:0]        out_wall_distance;
  logic               out_wall_side;
  logic               out_wall_found;

  int fail_count;
  int pending;
  int burst_left;
  bit hold_req;

  grid_raycast_column uut (.*);

  grc_scoreboard u_checker (.*);

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  // Hard stop in case the block hangs.
  initial begin
    #20ms;
    $display("grid_raycast_column regression: fail");
    $finish;
  end

  // Result side: mostly a stall pattern of its own, plus one long hold-off on request.
  initial begin
    int unsigned tick;
    tick = 0;
    out_ready = 0;
    forever begin
      @(negedge clk);
      tick++;
      if (hold_req) begin
        out_ready <= 0;
        repeat (600) @(negedge clk);
        hold_req = 0;
      end else if (tick[7]) begin
        out_ready <= ($urandom_range(0, 2) != 0);
      end else if (tick[6]) begin
        out_ready <= ($urandom_range(0, 4) == 0);
      end else begin
        out_ready <= 1;
      end
    end
  end

  // Offer one word, honoring the burst and gap pattern; returns at the next falling edge.
  task automatic offer_word(input logic act, input logic [3:0] cx, input logic [3:0] cy,
                            input logic wl, input logic [15:0] vx, input logic [15:0] vy,
                            input logic [15:0] hx, input logic [15:0] hy,
                            input logic [15:0] px, input logic [15:0] py,
                            input logic [5:0] col);
    if (burst_left == 0) begin
      in_valid <= 0;
      repeat ($urandom_range(1, 12)) @(negedge clk);
      burst_left = ($urandom_range(0, 3) == 0) ? 40 : $urandom_range(1, 10);
    end
    burst_left--;
    in_valid      <= 1;
    in_action     <= act;
    in_cell_x     <= cx;
    in_cell_y     <= cy;
    in_cell_wall  <= wl;
    in_view_x     <= vx;
    in_view_y     <= vy;
    in_heading_x  <= hx;
    in_heading_y  <= hy;
    in_plane_x_in <= px;
    in_plane_y_in <= py;
    in_column     <= col;
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
  endtask

  task automatic write_cell(input logic [3:0] cx, input logic [3:0] cy, input logic wl);
    offer_word(ACT_WRITE, cx, cy, wl, 16'($urandom), 16'($urandom), 16'($urandom),
               16'($urandom), 16'($urandom), 16'($urandom), 6'($urandom));
  endtask

  task automatic cast_ray(input logic [15:0] vx, input logic [15:0] vy,
                          input logic [15:0] hx, input logic [15:0] hy,
                          input logic [15:0] px, input logic [15:0] py,
                          input logic [5:0] col);
    offer_word(ACT_CAST, 4'($urandom), 4'($urandom), 1'($urandom), vx, vy, hx, hy, px, py,
               col);
  endtask

  // Random room: solid border plus a few interior cells, then casts, mostly from inside, mixed with writes.
  task automatic run_room(input int casts);
    int k;
    for (k = 0; k < GRID_SIDE; k++) begin
      write_cell(4'(k), 4'd0, 1'b1);
      write_cell(4'(k), 4'(GRID_SIDE - 1), 1'b1);
      if (k > 0 && k < GRID_SIDE - 1) begin
        write_cell(4'd0, 4'(k), 1'b1);
        write_cell(4'(GRID_SIDE - 1), 4'(k), 1'b1);
      end
    end
    repeat (12) write_cell(4'($urandom_range(1, 14)), 4'($urandom_range(1, 14)),
                           1'($urandom));
    for (k = 0; k < casts; k++) begin
      case ($urandom_range(0, 9))
        0: write_cell(4'($urandom), 4'($urandom), 1'($urandom));
        1: cast_ray(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom),
                    16'($urandom), 16'($urandom), 6'($urandom));
        2: cast_ray({4'($urandom_range(1, 14)), 12'($urandom)},
                    {4'($urandom_range(1, 14)), 12'($urandom)},
                    0, 0, $urandom_range(0, 1) ? 16'sd0 : 16'($urandom), 0, 6'($urandom));
        default:
          cast_ray({4'($urandom_range(1, 14)), 12'($urandom)},
                   {4'($urandom_range(1, 14)), 12'($urandom)},
                   16'($urandom_range(0, 32768) - 16384), 16'($urandom_range(0, 32768) - 16384),
                   16'($urandom_range(0, 21846) - 10923), 16'($urandom_range(0, 21846) - 10923),
                   6'($urandom));
      endcase
    end
  endtask

  initial begin
    rst_n         = 0;
    in_valid      = 0;
    in_action     = ACT_WRITE;
    in_cell_x     = 0;
    in_cell_y     = 0;
    in_cell_wall  = 0;
    in_view_x     = 0;
    in_view_y     = 0;
    in_heading_x  = 0;
    in_heading_y  = 0;
    in_plane_x_in = 0;
    in_plane_y_in = 0;
    in_column     = 0;
    hold_req      = 0;
    burst_left    = 0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n = 1;

    // Directed: empty grid, so the ray leaves the map without a hit.
    cast_ray(16'h8800, 16'h8800, 16'sd16384, 0, 0, 16'sd10923, 0);
    // Both ray components zero on an empty grid.
    cast_ray(16'h5800, 16'h5400, 0, 0, 0, 0, 32);
    // Viewer exactly on a boundary facing a wall next to it: zero distance.
    write_cell(1, 8, 1);
    cast_ray(16'h2000, 16'h8800, -16'sd16384, 0, 0, 0, 32);
    // Zero component on the stepped axis: saturated distance but a hit.
    write_cell(5, 6, 1);
    cast_ray(16'h5800, 16'h5800, 0, 0, 0, 0, 32);
    // Field extremes and both column ends.
    write_cell(15, 15, 1);
    write_cell(0, 0, 1);
    cast_ray(16'hFFFF, 16'hFFFF, 16'sh7FFF, -16'sh8000, -16'sh8000, 16'sh7FFF, 63);
    cast_ray(16'h0000, 16'h0000, -16'sh8000, 16'sh7FFF, 16'sh7FFF, -16'sh8000, 0);
    cast_ray(16'h0FFF, 16'hF000, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 63);
    cast_ray(16'h5800, 16'h8800, 0, 16'sd16384, 16'sd10923, 0, 1);
    write_cell(15, 15, 0);
    write_cell(1, 8, 0);
    cast_ray(16'h2000, 16'h8800, -16'sd16384, 0, 0, 0, 32);

    // Random rooms; the second one sees a long result hold-off.
    run_room(120);
    hold_req = 1;
    run_room(120);
    run_room(110);
    // Sender pauses until every result is back, then one more room.
    in_valid <= 0;
    wait (pending == 0);
    @(negedge clk);
    run_room(90);
    in_valid <= 0;

    wait (pending == 0);
    repeat (300) @(posedge clk);
    if (fail_count == 0)
      $display("grid_raycast_column regression: pass");
    else
      $display("grid_raycast_column regression: fail");
    $finish;
  end

endmodule
